FILE: design/tape_pulse_byte_decoder_assert.svh
// Assertion macros used by the result queue module of the tape pulse byte decoder.
// Depends on nothing; the checks compile away when SYNTHESIS is defined.
`ifndef TAPE_PULSE_BYTE_DECODER_ASSERT_SVH
`define TAPE_PULSE_BYTE_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define TPBD_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tape pulse byte decoder assertion failed");
`define TPBD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tape pulse byte decoder assertion failed");
`else
`define TPBD_ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define TPBD_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

FILE: design/tpbd_pkg.sv
// Types and constants of the tape pulse byte decoder.
// Used by every module of the block; depends on nothing.
package tpbd_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_PAUSE_MIN = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_MAX = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_PULSES = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ONE_PULSES = 8'd3;

    localparam logic [15:0] PAUSE_MIN_RESET = 16'd1950;
    localparam logic [15:0] PULSE_MAX_RESET = 16'd1462;
    localparam logic [4:0] ZERO_PULSES_RESET = 5'd8;
    localparam logic [4:0] ONE_PULSES_RESET = 5'd18;

    localparam logic [4:0] TALLY_MAX = 5'd31;

    typedef enum logic [1:0] {
        STATUS_OK = 2'd0,
        STATUS_SHORT_PAUSE = 2'd1,
        STATUS_BAD_COUNT = 2'd2
    } status_t;

    typedef struct packed {
        logic [15:0] period_ticks;
        logic resync;
    } in_item_t;

    typedef struct packed {
        logic [7:0] data_byte;
        status_t status;
        logic last_in_run;
    } result_t;

    typedef struct packed {
        logic two;
        result_t first;
        result_t second;
    } result_pair_t;

    typedef struct packed {
        logic [15:0] pause_min;
        logic [15:0] pulse_max;
        logic [4:0] zero_pulses;
        logic [4:0] one_pulses;
    } cfg_regs_t;

endpackage

FILE: design/tpbd_cfg.sv
// Configuration register file of the tape pulse byte decoder.
// Depends on tpbd_pkg for the register indexes and reset values.
module tpbd_cfg (
    input  logic aclk,
    input  logic aresetn,
    input  logic cfg_valid,
    input  logic [tpbd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tpbd_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic cfg_ready,
    output tpbd_pkg::cfg_regs_t cfg
);
    import tpbd_pkg::*;

    cfg_regs_t cfg_reg;
    cfg_regs_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_PAUSE_MIN: cfg_next.pause_min = cfg_data;
                CFG_PULSE_MAX: cfg_next.pulse_max = cfg_data;
                CFG_ZERO_PULSES: cfg_next.zero_pulses = cfg_data[4:0];
                CFG_ONE_PULSES: cfg_next.one_pulses = cfg_data[4:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pause_min <= PAUSE_MIN_RESET;
            cfg_reg.pulse_max <= PULSE_MAX_RESET;
            cfg_reg.zero_pulses <= ZERO_PULSES_RESET;
            cfg_reg.one_pulses <= ONE_PULSES_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: design/tpbd_core.sv
// Input register and period judging logic with the decoder state.
// Depends on tpbd_pkg; pushes result pairs into tpbd_fifo.
module tpbd_core (
    input  logic aclk,
    input  logic aresetn,
    input  tpbd_pkg::cfg_regs_t cfg,
    input  logic s_valid,
    input  tpbd_pkg::in_item_t s_item,
    output logic s_ready,
    input  logic fifo_space,
    output logic push,
    output tpbd_pkg::result_pair_t push_pair
);
    import tpbd_pkg::*;

    logic in_valid_reg;
    in_item_t in_item_reg;
    logic advance;

    logic counting_reg, counting_next;
    logic [4:0] tally_reg, tally_next;
    logic [3:0] bits_reg, bits_next;
    logic [7:0] shift_reg, shift_next;

    logic c_cur;
    logic [4:0] t_cur;
    logic [3:0] b_cur;
    logic [7:0] s_cur;
    logic is_long, is_short, is_zero, is_one;
    logic [7:0] s_shift;
    logic [3:0] b_inc;
    result_t res [2];
    logic [1:0] n_res;

    assign advance = in_valid_reg && fifo_space;
    assign s_ready = !in_valid_reg || fifo_space;

    always_comb begin
        c_cur = in_item_reg.resync ? 1'b0 : counting_reg;
        t_cur = in_item_reg.resync ? 5'd0 : tally_reg;
        b_cur = in_item_reg.resync ? 4'd0 : bits_reg;
        s_cur = in_item_reg.resync ? 8'd0 : shift_reg;
        is_long = in_item_reg.period_ticks >= cfg.pause_min;
        is_short = in_item_reg.period_ticks <= cfg.pulse_max;
        is_zero = t_cur == cfg.zero_pulses;
        is_one = t_cur == cfg.one_pulses;
        s_shift = {s_cur[6:0], !is_zero};
        b_inc = b_cur + 4'd1;

        counting_next = c_cur;
        tally_next = t_cur;
        bits_next = b_cur;
        shift_next = s_cur;
        n_res = 2'd0;
        res[0] = '{data_byte: 8'd0, status: STATUS_OK, last_in_run: 1'b0};
        res[1] = res[0];

        if (!c_cur) begin
            if (is_long) begin
                counting_next = 1'b1;
                tally_next = 5'd0;
            end
        end else if (is_short) begin
            if (t_cur != TALLY_MAX) begin
                tally_next = t_cur + 5'd1;
            end
        end else if (!is_zero && !is_one) begin
            res[0].status = STATUS_BAD_COUNT;
            n_res = 2'd1;
            counting_next = is_long;
            tally_next = 5'd0;
            bits_next = 4'd0;
            shift_next = 8'd0;
        end else begin
            tally_next = 5'd0;
            if (b_inc[3]) begin
                res[0].data_byte = s_shift;
                n_res = 2'd1;
                bits_next = 4'd0;
                shift_next = 8'd0;
            end else begin
                bits_next = b_inc;
                shift_next = s_shift;
            end
            if (!is_long) begin
                res[n_res[0]].data_byte = 8'd0;
                res[n_res[0]].status = STATUS_SHORT_PAUSE;
                n_res = n_res + 2'd1;
                counting_next = 1'b0;
                bits_next = 4'd0;
                shift_next = 8'd0;
            end
        end

        res[0].last_in_run = n_res == 2'd1;
        res[1].last_in_run = 1'b1;
        push = advance && (n_res != 2'd0);
        push_pair.two = n_res == 2'd2;
        push_pair.first = res[0];
        push_pair.second = res[1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            counting_reg <= 1'b0;
            tally_reg <= 5'd0;
            bits_reg <= 4'd0;
            shift_reg <= 8'd0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                counting_reg <= counting_next;
                tally_reg <= tally_next;
                bits_reg <= bits_next;
                shift_reg <= shift_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

endmodule

FILE: design/tpbd_fifo.sv
// Result queue of the tape pulse byte decoder; each entry holds one or two items.
// Depends on tpbd_pkg and on the assertion macro header.
`include "tape_pulse_byte_decoder_assert.svh"
module tpbd_fifo #(
    parameter int DEPTH = 2
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  tpbd_pkg::result_pair_t push_pair,
    output logic space,
    output logic m_valid,
    input  logic m_ready,
    output tpbd_pkg::result_t m_result
);
    import tpbd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    result_pair_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic half_reg;
    result_pair_t head;
    logic take, pop;

    assign head = mem[rd_ptr_reg];
    assign space = count_reg != CNT_FULL;
    assign m_valid = count_reg != '0;
    assign m_result = half_reg ? head.second : head.first;
    assign take = m_valid && m_ready;
    assign pop = take && (half_reg || !head.two);

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_pair;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
            half_reg <= 1'b0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (take) begin
                half_reg <= !pop;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `TPBD_ASSERT_IMPLIES(a_no_push_when_full, aclk, aresetn, push, count_reg != CNT_FULL)
    `TPBD_ASSERT_IMPLIES(a_half_needs_entry, aclk, aresetn, half_reg, m_valid && head.two)
    `TPBD_ASSERT_IMPLIES(a_second_is_last, aclk, aresetn, m_valid && half_reg, m_result.last_in_run)
    `TPBD_ASSERT_NEXT(a_split_holds, aclk, aresetn, take && !pop, m_valid && half_reg)

endmodule

FILE: design/tape_pulse_byte_decoder.sv
// Pulse-count cassette byte decoder: one tape period per input item, up to two result items.
// An item is held in the input register, then its results are written to the result queue.
// Throughput is one item per cycle while the result queue has space, set by the input
// register and one result queue write; an item causing two results fills one entry with both.
// Reset is synchronous on aresetn low: decoder state and queue clear, registers take defaults.
module tape_pulse_byte_decoder #(
    parameter int FIFO_DEPTH = 2
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  tpbd_pkg::in_item_t s_item,
    output logic m_valid,
    input  logic m_ready,
    output tpbd_pkg::result_t m_result,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [tpbd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tpbd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tpbd_pkg::*;

    cfg_regs_t cfg;
    logic fifo_space;
    logic push;
    result_pair_t push_pair;

    tpbd_cfg u_cfg (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .cfg_ready(cfg_ready),
        .cfg(cfg)
    );

    tpbd_core u_core (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg(cfg),
        .s_valid(s_valid),
        .s_item(s_item),
        .s_ready(s_ready),
        .fifo_space(fifo_space),
        .push(push),
        .push_pair(push_pair)
    );

    tpbd_fifo #(
        .DEPTH(FIFO_DEPTH)
    ) u_fifo (
        .aclk(aclk),
        .aresetn(aresetn),
        .push(push),
        .push_pair(push_pair),
        .space(fifo_space),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_result(m_result)
    );

endmodule
